### hdl/tpdp_pkg.sv
// Package for the ternary packed dot product block.
// Holds weight format codes, the trit encoding and the base-3 digit tables.
// No dependencies; used by every other file of the block.
`timescale 1ns / 1ps

package tpdp_pkg;

  // Number of weights one item can carry.
  localparam int unsigned NumLanes = 5;
  localparam int unsigned ActW     = 8;
  localparam int unsigned TermW    = ActW + 1;
  localparam int unsigned SumW     = 32;

  // Weight format register codes.
  localparam logic [1:0] FMT_BASE3    = 2'd0;
  localparam logic [1:0] FMT_SIGNMASK = 2'd1;
  localparam logic [1:0] FMT_FIVE     = 2'd2;

  // Packing constants for the five-per-byte format.
  localparam logic [5:0] DIV9_MUL   = 6'd57;
  localparam int unsigned DIV9_SHIFT = 9;
  localparam logic [4:0] HIGH_MAX   = 5'd26;

  // A decoded weight. The encoding matches a base-3 digit so digits map directly.
  typedef logic [1:0] trit_t;
  localparam trit_t TRIT_ZERO = 2'd0;
  localparam trit_t TRIT_POS  = 2'd1;
  localparam trit_t TRIT_NEG  = 2'd2;

  typedef trit_t [NumLanes-1:0] weights_t;
  typedef logic signed [TermW-1:0] term_t;
  typedef term_t [NumLanes-1:0] terms_t;

  // Two base-3 digits of a value below nine, digit 1 in the upper half.
  function automatic logic [3:0] low_digits(input logic [3:0] v);
    logic [3:0] res;
    res = '0;
    for (int i = 0; i < 9; i++) begin
      if (v == 4'(i)) begin
        res = {2'(i / 3), 2'(i % 3)};
      end
    end
    return res;
  endfunction

  // Three base-3 digits of a value below 27; larger values give all zeros.
  function automatic logic [5:0] high_digits(input logic [4:0] v);
    logic [5:0] res;
    res = '0;
    for (int i = 0; i < 27; i++) begin
      if (v == 5'(i)) begin
        res = {2'(i / 9), 2'((i / 3) % 3), 2'(i % 3)};
      end
    end
    return res;
  endfunction

endpackage

### hdl/tpdp_if.sv
// Stream interfaces for the ternary packed dot product block.
// Input items carry a weight byte and activations; output items carry the sum.
// Depends on tpdp_pkg for widths.
`timescale 1ns / 1ps

interface tpdp_in_if import tpdp_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [7:0]               packed_byte;
  logic signed [ActW-1:0]   act0;
  logic signed [ActW-1:0]   act1;
  logic signed [ActW-1:0]   act2;
  logic signed [ActW-1:0]   act3;
  logic signed [ActW-1:0]   act4;
  logic                     last;

  modport source (output valid, packed_byte, act0, act1, act2, act3, act4, last,
                  input ready);
  modport sink   (input valid, packed_byte, act0, act1, act2, act3, act4, last,
                  output ready);
endinterface

interface tpdp_out_if import tpdp_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [SumW-1:0]   dot_sum;

  modport source (output valid, dot_sum, input ready);
  modport sink   (input valid, dot_sum, output ready);
endinterface

### hdl/tpdp_decode.sv
// Weight byte decoder: turns one packed byte into five ternary weights.
// Depends on tpdp_pkg for format codes, trit encoding and digit tables.
`timescale 1ns / 1ps

module tpdp_decode import tpdp_pkg::*; (
  input  logic [7:0] packed_byte_i,
  input  logic [1:0] weight_format_i,
  output weights_t   weights_o
);

  logic [13:0] prod;
  logic [4:0]  high;
  logic [3:0]  low;
  logic [3:0]  low_dig;
  logic [5:0]  high_dig;
  logic [1:0]  code;

  // Divide by nine through the reciprocal multiply; the remainder is below nine.
  assign prod     = 14'(packed_byte_i) * 14'(DIV9_MUL);
  assign high     = prod[DIV9_SHIFT +: 5];
  assign low      = 4'(packed_byte_i - 8'(high) * 8'd9);
  assign low_dig  = low_digits(low);
  assign high_dig = high_digits(high);

  // Select the decode by the weight format.
  always_comb begin
    weights_o = '{default: TRIT_ZERO};
    code      = '0;
    case (weight_format_i)
      FMT_BASE3: begin
        for (int p = 0; p < 4; p++) begin
          code         = packed_byte_i[2*p +: 2];
          weights_o[p] = (code == 2'b11) ? TRIT_ZERO : trit_t'(code);
        end
      end
      FMT_SIGNMASK: begin
        for (int p = 0; p < 4; p++) begin
          code         = packed_byte_i[2*p +: 2];
          weights_o[p] = code[1] ? TRIT_ZERO : (code[0] ? TRIT_NEG : TRIT_POS);
        end
      end
      FMT_FIVE: begin
        weights_o[0] = low_dig[1:0];
        weights_o[1] = low_dig[3:2];
        // Values of high beyond the trit range decode as zero in the table.
        if (high <= HIGH_MAX) begin
          weights_o[2] = high_dig[1:0];
          weights_o[3] = high_dig[3:2];
          weights_o[4] = high_dig[5:4];
        end
      end
      default: begin
        weights_o = '{default: TRIT_ZERO};
      end
    endcase
  end

endmodule

### hdl/tpdp_lane.sv
// One multiply lane: applies a ternary weight to a signed activation.
// Depends on tpdp_pkg for the trit encoding and term width.
`timescale 1ns / 1ps

module tpdp_lane import tpdp_pkg::*; (
  input  trit_t                  weight_i,
  input  logic signed [ActW-1:0] act_i,
  output term_t                  term_o
);

  term_t act_ext;

  assign act_ext = TermW'(act_i);

  // Add, subtract or drop the activation.
  always_comb begin
    case (weight_i)
      TRIT_POS: term_o = act_ext;
      TRIT_NEG: term_o = -act_ext;
      default:  term_o = '0;
    endcase
  end

endmodule

### hdl/ternary_packed_dot_product_top.sv
// Top level of the ternary packed dot product block.
// Instantiates tpdp_decode and five tpdp_lane copies, then merges and accumulates.
// Depends on tpdp_pkg and the interfaces in tpdp_if.
//
//   channel       direction  payload                                  handshake
//   in_i          in         packed_byte, act0..act4, last            valid/ready
//   out_o         out        dot_sum                                  valid/ready
//   weight_format in         2-bit format, written on weight_format_we_i  none
//
// One item is accepted every cycle unless the term stage stalls; decode and the
// five lanes fill a term register, and the merge stage adds the terms into the
// running sum as that register drains. A last item's sum passes through the term
// register and then the output register, where it waits until out_o takes it.
// Input stalls only when a last item waits in the term stage behind a full output.
// Reset clears the running sum, the format and all valid flags.
`timescale 1ns / 1ps

module ternary_packed_dot_product_top import tpdp_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             weight_format_we_i,
  input  logic [1:0]       weight_format_i,
  tpdp_in_if.sink          in_i,
  tpdp_out_if.source       out_o
);

  logic [1:0]                 fmt_q;
  weights_t                   weights;
  logic signed [ActW-1:0]     acts [NumLanes];
  terms_t                     terms;
  terms_t                     terms_q;
  logic                       a_valid_q;
  logic                       a_last_q;
  logic                       a_fire;
  logic                       in_fire;
  logic signed [SumW-1:0]     acc_q;
  logic signed [SumW-1:0]     acc_d;
  logic signed [SumW-1:0]     term_sum;
  logic                       out_valid_q;
  logic signed [SumW-1:0]     out_sum_q;

  // Configuration register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fmt_q <= FMT_BASE3;
    end else if (weight_format_we_i) begin
      fmt_q <= weight_format_i;
    end
  end

  // Byte decode.
  tpdp_decode u_decode (
    .packed_byte_i   (in_i.packed_byte),
    .weight_format_i (fmt_q),
    .weights_o       (weights)
  );

  assign acts[0] = in_i.act0;
  assign acts[1] = in_i.act1;
  assign acts[2] = in_i.act2;
  assign acts[3] = in_i.act3;
  assign acts[4] = in_i.act4;

  // Parallel lanes, one per weight position.
  for (genvar g = 0; g < NumLanes; g++) begin : g_lane
    tpdp_lane u_lane (
      .weight_i (weights[g]),
      .act_i    (acts[g]),
      .term_o   (terms[g])
    );
  end

  // Handshake: the term stage drains unless a last item meets a full output.
  assign a_fire     = a_valid_q && (!a_last_q || !out_valid_q || out_o.ready);
  assign in_i.ready = !a_valid_q || a_fire;
  assign in_fire    = in_i.valid && in_i.ready;

  // Term stage.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      a_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      terms_q  <= terms;
      a_last_q <= in_i.last;
    end
  end

  // Merge the lane terms and add them to the running sum.
  always_comb begin
    term_sum = '0;
    for (int p = 0; p < NumLanes; p++) begin
      term_sum = term_sum + SumW'(terms_q[p]);
    end
    acc_d = acc_q + term_sum;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
    end else if (a_fire) begin
      acc_q <= a_last_q ? '0 : acc_d;
    end
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (a_fire && a_last_q) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_fire && a_last_q) begin
      out_sum_q <= acc_d;
    end
  end

  assign out_o.valid   = out_valid_q;
  assign out_o.dot_sum = out_sum_q;

endmodule

### tb/sv/tb.sv
// Testbench for ternary_packed_dot_product_top: streams packed weight bytes and
// activations, predicts each dot product sum and checks it against the output.
// Depends on tpdp_pkg, the stream interfaces in tpdp_if and the RTL top level.
`timescale 1ns / 1ps

module tb;
  import tpdp_pkg::*;

  localparam int unsigned HoldCycles   = 60;
  localparam int unsigned CycleLimit   = 200000;
  localparam int unsigned IdlePct      = 13;
  localparam int unsigned SettleCycles = 6;
  localparam logic [1:0]  FmtUnused    = 2'd3;
  localparam logic [7:0]  ActMin       = 8'h80;
  localparam logic [7:0]  ActMax       = 8'h7F;

  // One input item: the weight byte, five activations and the end flag.
  typedef struct packed {
    logic [7:0]      wbyte;
    logic [4:0][7:0] acts;
    logic            last;
  } dp_item_t;

  logic       clk_i    = 1'b0;
  logic       rst_ni   = 1'b0;
  logic       fmt_we   = 1'b0;
  logic [1:0] fmt_data = FMT_BASE3;

  tpdp_in_if  in_if ();
  tpdp_out_if out_if ();

  ternary_packed_dot_product_top dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .weight_format_we_i (fmt_we),
    .weight_format_i    (fmt_data),
    .in_i               (in_if),
    .out_o              (out_if)
  );

  dp_item_t    pending_items[$];
  logic [31:0] expected_sums[$];
  logic [1:0]  model_format = FMT_BASE3;
  logic [31:0] model_sum    = '0;
  dp_item_t    offered_item;
  logic        steady  = 1'b0;
  logic        hold_go = 1'b0;
  logic        hold_seen;
  int unsigned hold_left;
  int unsigned error_count = 0;
  int unsigned cycle_count = 0;

  always #5 clk_i = ~clk_i;

  // Hard limit on the run length.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    error_count++;
  endtask

  // A base-3 digit maps to a weight the same way a format 0 code does.
  function automatic int trit_weight(input int d);
    if (d == int'(TRIT_POS)) return 1;
    if (d == int'(TRIT_NEG)) return -1;
    return 0;
  endfunction

  // Decode the weights of one item, add it into the running sum and queue
  // the sum when the item closes a dot product.
  task automatic accumulate_item(input dp_item_t it);
    int          w[5];
    int          b;
    int          hi;
    int          lo;
    logic [1:0]  code;
    logic [31:0] a;
    for (int p = 0; p < 5; p++) w[p] = 0;
    b = int'(it.wbyte);
    case (model_format)
      FMT_BASE3: begin
        for (int p = 0; p < 4; p++) w[p] = trit_weight(int'(it.wbyte[2*p +: 2]));
      end
      FMT_SIGNMASK: begin
        // Upper bit masks the weight out, lower bit gives the sign.
        for (int p = 0; p < 4; p++) begin
          code = it.wbyte[2*p +: 2];
          w[p] = code[1] ? 0 : (code[0] ? -1 : 1);
        end
      end
      FMT_FIVE: begin
        hi   = (b * 57) >> 9;
        lo   = b - 9 * hi;
        w[0] = trit_weight(lo % 3);
        w[1] = trit_weight(lo / 3);
        if (hi <= 26) begin
          w[2] = trit_weight(hi % 3);
          w[3] = trit_weight((hi / 3) % 3);
          w[4] = trit_weight(hi / 9);
        end
      end
      default: ;
    endcase
    for (int p = 0; p < 5; p++) begin
      a = {{24{it.acts[p][7]}}, it.acts[p]};
      if (w[p] > 0) model_sum = model_sum + a;
      else if (w[p] < 0) model_sum = model_sum - a;
    end
    if (it.last) begin
      expected_sums.push_back(model_sum);
      model_sum = '0;
    end
  endtask

  function automatic dp_item_t make_item(input logic [7:0] b, input logic [7:0] a0,
                                         input logic [7:0] a1, input logic [7:0] a2,
                                         input logic [7:0] a3, input logic [7:0] a4,
                                         input logic last);
    dp_item_t it;
    it.wbyte = b;
    it.acts  = {a4, a3, a2, a1, a0};
    it.last  = last;
    return it;
  endfunction

  // Random content, leaning toward extreme activations and high bytes now and then.
  function automatic dp_item_t random_item();
    dp_item_t it;
    it.wbyte = ($urandom_range(0, 7) == 0) ? 8'($urandom_range(243, 255))
                                           : 8'($urandom_range(0, 255));
    for (int p = 0; p < 5; p++) begin
      if ($urandom_range(0, 9) == 0) it.acts[p] = $urandom_range(0, 1) ? ActMin : ActMax;
      else it.acts[p] = 8'($urandom_range(0, 255));
    end
    it.last = 1'b0;
    return it;
  endfunction

  // Queue whole dot products of random length, each closed by a last item.
  task automatic fill_dot_products(input int count);
    int       n;
    int       len;
    dp_item_t it;
    n = 0;
    while (n < count) begin
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
      if (len > count - n) len = count - n;
      for (int i = 0; i < len; i++) begin
        it      = random_item();
        it.last = (i == len - 1);
        pending_items.push_back(it);
      end
      n += len;
    end
  endtask

  // Wait until every item is taken and every sum has come back, then let the
  // pipeline settle so a trailing item without a sum is fully absorbed.
  task automatic wait_drained();
    do @(negedge clk_i);
    while (pending_items.size() != 0 || in_if.valid || expected_sums.size() != 0);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_format(input logic [1:0] code);
    @(posedge clk_i);
    fmt_we   <= 1'b1;
    fmt_data <= code;
    @(posedge clk_i);
    fmt_we       <= 1'b0;
    model_format = code;
  endtask

  // Input driver: predicts on each accepted item and offers the next one.
  always @(posedge clk_i or negedge rst_ni) begin : drive_items
    dp_item_t nxt;
    logic     busy;
    if (!rst_ni) begin
      in_if.valid       <= 1'b0;
      in_if.packed_byte <= '0;
      in_if.act0        <= '0;
      in_if.act1        <= '0;
      in_if.act2        <= '0;
      in_if.act3        <= '0;
      in_if.act4        <= '0;
      in_if.last        <= 1'b0;
    end else begin
      busy = in_if.valid && !in_if.ready;
      if (in_if.valid && in_if.ready) accumulate_item(offered_item);
      if (!busy) begin
        if (pending_items.size() != 0 && (steady || $urandom_range(0, 99) >= IdlePct)) begin
          nxt               = pending_items.pop_front();
          offered_item      = nxt;
          in_if.valid       <= 1'b1;
          in_if.packed_byte <= nxt.wbyte;
          in_if.act0        <= nxt.acts[0];
          in_if.act1        <= nxt.acts[1];
          in_if.act2        <= nxt.acts[2];
          in_if.act3        <= nxt.acts[3];
          in_if.act4        <= nxt.acts[4];
          in_if.last        <= nxt.last;
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // Output monitor: checks each sum and drives ready with random and long stalls.
  always @(posedge clk_i or negedge rst_ni) begin : watch_sums
    logic [31:0] want;
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
      hold_seen    <= 1'b0;
      hold_left    <= 0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        if (expected_sums.size() == 0) begin
          report_mismatch($sformatf("sum %0d arrived with none expected", out_if.dot_sum));
        end else begin
          want = expected_sums.pop_front();
          if (out_if.dot_sum !== want)
            report_mismatch($sformatf("dot_sum got %0d, expected %0d",
                                      out_if.dot_sum, $signed(want)));
        end
      end
      if (hold_go != hold_seen) begin
        hold_seen    <= hold_go;
        hold_left    <= HoldCycles;
        out_if.ready <= 1'b0;
      end else if (hold_left != 0) begin
        hold_left    <= hold_left - 1;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= steady || ($urandom_range(0, 99) >= IdlePct);
      end
    end
  end

  // Stimulus sequence: directed corners per format, then random dot products.
  initial begin
    in_if.valid       = 1'b0;
    in_if.packed_byte = '0;
    in_if.act0        = '0;
    in_if.act1        = '0;
    in_if.act2        = '0;
    in_if.act3        = '0;
    in_if.act4        = '0;
    in_if.last        = 1'b0;
    out_if.ready      = 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Format 0: all +1, all -1, all zero codes, a mix of every code.
    write_format(FMT_BASE3);
    pending_items.push_back(make_item(8'h55, ActMax, ActMax, ActMax, ActMax, ActMin, 1'b0));
    pending_items.push_back(make_item(8'hAA, ActMin, ActMin, ActMin, ActMin, ActMax, 1'b0));
    pending_items.push_back(make_item(8'hFF, 8'd5, 8'd6, 8'd7, 8'd8, 8'd9, 1'b1));
    pending_items.push_back(make_item(8'h00, ActMax, ActMin, ActMax, ActMin, ActMax, 1'b1));
    pending_items.push_back(make_item(8'h1B, ActMin, ActMax, 8'hFF, 8'h01, ActMax, 1'b1));
    wait_drained();

    // Format 1: act4 must be ignored even when it is large.
    write_format(FMT_SIGNMASK);
    pending_items.push_back(make_item(8'h00, ActMin, ActMin, ActMin, ActMin, ActMax, 1'b0));
    pending_items.push_back(make_item(8'h55, ActMin, ActMin, ActMin, ActMin, ActMin, 1'b1));
    pending_items.push_back(make_item(8'hAA, ActMax, ActMax, ActMax, ActMax, ActMax, 1'b1));
    pending_items.push_back(make_item(8'hFF, ActMin, ActMax, ActMin, ActMax, ActMin, 1'b1));
    pending_items.push_back(make_item(8'hE4, ActMax, ActMin, 8'h11, 8'h22, ActMax, 1'b1));
    wait_drained();

    // Format 2: all +1, all -1, bytes whose high part exceeds 26, zero.
    write_format(FMT_FIVE);
    pending_items.push_back(make_item(8'd121, ActMax, ActMax, ActMax, ActMax, ActMax, 1'b0));
    pending_items.push_back(make_item(8'd242, ActMin, ActMin, ActMin, ActMin, ActMin, 1'b1));
    pending_items.push_back(make_item(8'd243, ActMax, ActMin, ActMax, ActMin, ActMax, 1'b1));
    pending_items.push_back(make_item(8'd250, ActMin, ActMax, ActMin, ActMax, ActMin, 1'b1));
    pending_items.push_back(make_item(8'd255, ActMax, ActMax, ActMax, ActMax, ActMax, 1'b1));
    pending_items.push_back(make_item(8'd0, ActMax, ActMax, ActMax, ActMax, ActMax, 1'b1));
    wait_drained();

    // Unused format code: nothing is added but last still emits and clears.
    write_format(FmtUnused);
    pending_items.push_back(make_item(8'h55, ActMax, ActMax, ActMax, ActMax, ActMax, 1'b0));
    pending_items.push_back(make_item(8'hFF, ActMin, ActMin, ActMin, ActMin, ActMin, 1'b1));
    pending_items.push_back(make_item(8'd121, ActMax, ActMax, ActMax, ActMax, ActMax, 1'b1));
    wait_drained();

    // Random phase with a long output stall while the sender keeps offering.
    write_format(FMT_FIVE);
    fill_dot_products(140);
    hold_go = ~hold_go;
    wait_drained();

    // Back-to-back traffic on both sides.
    write_format(FMT_SIGNMASK);
    steady = 1'b1;
    fill_dot_products(140);
    wait_drained();
    steady = 1'b0;

    // The sender pauses halfway until every sum has come back.
    write_format(FMT_BASE3);
    fill_dot_products(70);
    wait_drained();
    fill_dot_products(70);
    wait_drained();

    write_format(FmtUnused);
    fill_dot_products(80);
    wait_drained();

    write_format(FMT_FIVE);
    fill_dot_products(200);
    wait_drained();

    if (error_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
